FILE: hdl/poet_pkg.sv
// ----------------------------------------------------------------------------
// poet_pkg
// Types, codes and defaults shared by the periodic and one-shot event table.
// ----------------------------------------------------------------------------
package poet_pkg;

  localparam int REC_SLOTS_DEF = 8;
  localparam int ONE_SLOTS_DEF = 8;
  localparam int EVENT_IDS_DEF = 16;

  typedef enum logic [2:0] {
    ACT_TICK      = 3'd0,
    ACT_START_REC = 3'd1,
    ACT_KILL_REC  = 3'd2,
    ACT_START_ONE = 3'd3,
    ACT_LENGTHEN  = 3'd4,
    ACT_EXTING    = 3'd5
  } action_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_NOT_FOUND = 2'd1,
    ST_FULL      = 2'd2
  } status_t;

  typedef struct packed {
    logic [2:0]         action;
    logic [3:0]         event_id;
    logic               phase;
    logic signed [15:0] time_value;
  } in_item_t;

  typedef struct packed {
    logic [1:0] status;
    logic       fired_valid;
    logic [3:0] fired_id;
    logic       fired_kind;
    logic       last;
  } out_item_t;

  // controller -> datapath
  typedef struct packed {
    logic load;       // capture the command
    logic exec_cmd;   // carry out a non-tick command
    logic rec_step;   // examine recurring slot at the walk index
    logic one_step;   // examine one-shot slot at the walk index
    logic idx_clr;    // restart the walk index
    logic fin;        // close the tick: commit compaction, emit final result
  } poet_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic is_tick;
    logic rec_done;   // walk index past the last recurring slot
    logic one_done;   // walk index past the last one-shot slot
  } poet_stat_t;

endpackage

FILE: hdl/poet_ctrl.sv
// ----------------------------------------------------------------------------
// poet_ctrl
// Sequencer: command, recurring walk, one-shot walk, final result.
// ----------------------------------------------------------------------------
module poet_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  poet_pkg::poet_stat_t stat,
  output poet_pkg::poet_cmd_t  cmd
);

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_DEC  = 5'b00010,
    S_REC  = 5'b00100,
    S_ONE  = 5'b01000,
    S_FIN  = 5'b10000
  } state_t;

  state_t state_r, state_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd = '0;
    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          cmd.load = 1'b1;
          state_nxt = S_DEC;
        end
      end
      S_DEC: begin
        cmd.idx_clr = 1'b1;
        if (stat.is_tick) state_nxt = S_REC;
        else begin
          cmd.exec_cmd = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      S_REC: begin
        if (stat.rec_done) begin
          cmd.idx_clr = 1'b1;
          state_nxt = S_ONE;
        end else cmd.rec_step = 1'b1;
      end
      S_ONE: begin
        if (stat.one_done) state_nxt = S_FIN;
        else cmd.one_step = 1'b1;
      end
      S_FIN: begin
        cmd.fin = 1'b1;
        state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= S_IDLE;
    else state_r <= state_nxt;
  end

  assign busy = (state_r != S_IDLE);

endmodule

FILE: hdl/poet_dp.sv
// ----------------------------------------------------------------------------
// poet_dp
// Slot tables, walk index and result staging. Results are held back one
// step so that the final one can carry last.
// ----------------------------------------------------------------------------
module poet_dp #(
  parameter int REC_SLOTS = poet_pkg::REC_SLOTS_DEF,
  parameter int ONE_SLOTS = poet_pkg::ONE_SLOTS_DEF,
  parameter int EVENT_IDS = poet_pkg::EVENT_IDS_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  poet_pkg::in_item_t   in_item,
  input  poet_pkg::poet_cmd_t  cmd,
  output poet_pkg::poet_stat_t stat,
  output logic                 out_valid,
  output poet_pkg::out_item_t  out_item
);

  localparam int RW  = $clog2(REC_SLOTS + 1);
  localparam int OW  = $clog2(ONE_SLOTS + 1);
  localparam int IXW = (RW > OW) ? RW : OW;
  localparam int RIW = (REC_SLOTS > 1) ? $clog2(REC_SLOTS) : 1;
  localparam int OIW = (ONE_SLOTS > 1) ? $clog2(ONE_SLOTS) : 1;

  logic [3:0]         rid_r [REC_SLOTS];
  logic               rph_r [REC_SLOTS];
  logic [3:0]         oid_r [ONE_SLOTS];
  logic               oph_r [ONE_SLOTS];
  logic signed [15:0] otm_r [ONE_SLOTS];
  logic [RW-1:0]      rcnt_r;
  logic [OW-1:0]      ocnt_r;
  logic [IXW-1:0]     idx_r;
  logic [OW-1:0]      wr_r;      // one-shot compaction write pointer
  poet_pkg::in_item_t cur_r;
  logic [3:0]         id_m;

  // staged fired result
  logic               pend_r;
  logic [3:0]         pid_r;
  logic               pkind_r;
  logic               oval_r;
  poet_pkg::out_item_t oitem_r;

  // fold the id into range through a constant table
  always_comb begin
    id_m = in_item.event_id;
    for (int v = 0; v < 16; v++)
      if (in_item.event_id == 4'(v)) id_m = 4'(v % EVENT_IDS);
  end

  assign stat.is_tick  = (cur_r.action == poet_pkg::ACT_TICK);
  assign stat.rec_done = (idx_r >= IXW'(rcnt_r));
  assign stat.one_done = (idx_r >= IXW'(ocnt_r));

  // first-match searches (independent compares, priority pick)
  logic          rfound, ofound;
  logic [RIW-1:0] rpos;
  logic [OIW-1:0] opos;
  always_comb begin
    rfound = 1'b0;
    rpos   = '0;
    for (int i = REC_SLOTS - 1; i >= 0; i--)
      if (RW'(i) < rcnt_r && rid_r[i] == cur_r.event_id) begin
        rfound = 1'b1;
        rpos   = RIW'(i);
      end
    ofound = 1'b0;
    opos   = '0;
    for (int i = ONE_SLOTS - 1; i >= 0; i--)
      if (OW'(i) < ocnt_r && oid_r[i] == cur_r.event_id) begin
        ofound = 1'b1;
        opos   = OIW'(i);
      end
  end

  logic signed [16:0] lsum;
  logic signed [15:0] lsat;
  assign lsum = {otm_r[opos][15], otm_r[opos]} + {cur_r.time_value[15], cur_r.time_value};
  always_comb begin
    if (lsum > 17'sd32767) lsat = 16'sh7fff;
    else if (lsum < -17'sd32768) lsat = 16'sh8000;
    else lsat = lsum[15:0];
  end

  // status of a non-tick command
  logic [1:0] cmd_st;
  always_comb begin
    cmd_st = poet_pkg::ST_OK;
    unique case (cur_r.action)
      poet_pkg::ACT_START_REC:
        if (rcnt_r >= RW'(REC_SLOTS)) cmd_st = poet_pkg::ST_FULL;
      poet_pkg::ACT_KILL_REC:
        if (!rfound) cmd_st = poet_pkg::ST_NOT_FOUND;
      poet_pkg::ACT_START_ONE:
        if (ocnt_r >= OW'(ONE_SLOTS)) cmd_st = poet_pkg::ST_FULL;
      poet_pkg::ACT_LENGTHEN, poet_pkg::ACT_EXTING:
        if (!ofound) cmd_st = poet_pkg::ST_NOT_FOUND;
      default: ;
    endcase
  end

  // one-shot element at the walk index
  logic [OIW-1:0]     oix;
  logic [RIW-1:0]     rix;
  logic signed [15:0] dec_t;
  logic               o_match, o_fire;
  assign oix     = OIW'(idx_r);
  assign rix     = RIW'(idx_r);
  assign o_match = (oph_r[oix] == cur_r.phase);
  assign dec_t   = (otm_r[oix] == 16'sh8000) ? otm_r[oix] : otm_r[oix] - 16'sd1;
  assign o_fire  = o_match && (dec_t <= 16'sd0);

  logic       fire_now;
  logic [3:0] fire_id;
  logic       fire_kind;
  always_comb begin
    fire_now  = 1'b0;
    fire_id   = '0;
    fire_kind = 1'b0;
    if (cmd.rec_step && rph_r[rix] == cur_r.phase) begin
      fire_now = 1'b1;
      fire_id  = rid_r[rix];
    end else if (cmd.one_step && o_fire) begin
      fire_now  = 1'b1;
      fire_id   = oid_r[oix];
      fire_kind = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rcnt_r <= '0;
      ocnt_r <= '0;
      pend_r <= 1'b0;
      oval_r <= 1'b0;
    end else begin
      oval_r <= cmd.exec_cmd || cmd.fin || (fire_now && pend_r);
      if (cmd.load)
        cur_r <= '{action: in_item.action, event_id: id_m, phase: in_item.phase,
                   time_value: in_item.time_value};
      if (cmd.idx_clr) idx_r <= '0;
      else if (cmd.rec_step || cmd.one_step) idx_r <= idx_r + 1'b1;
      if (cmd.idx_clr) wr_r <= '0;
      else if (cmd.one_step && !o_fire) wr_r <= wr_r + 1'b1;
      if (cmd.one_step && !o_fire) begin
        oid_r[OIW'(wr_r)] <= oid_r[oix];
        oph_r[OIW'(wr_r)] <= oph_r[oix];
        otm_r[OIW'(wr_r)] <= o_match ? dec_t : otm_r[oix];
      end
      if (cmd.load || cmd.fin) pend_r <= 1'b0;
      else if (fire_now) pend_r <= 1'b1;
      if (fire_now) begin
        pid_r   <= fire_id;
        pkind_r <= fire_kind;
      end
      if (cmd.exec_cmd)
        oitem_r <= '{status: cmd_st, fired_valid: 1'b0,
                     fired_id: 4'd0, fired_kind: 1'b0, last: 1'b1};
      else if (cmd.fin)
        oitem_r <= '{status: poet_pkg::ST_OK, fired_valid: pend_r,
                     fired_id: pend_r ? pid_r : 4'd0,
                     fired_kind: pend_r & pkind_r, last: 1'b1};
      else if (fire_now && pend_r)
        oitem_r <= '{status: poet_pkg::ST_OK, fired_valid: 1'b1,
                     fired_id: pid_r, fired_kind: pkind_r, last: 1'b0};
      if (cmd.fin) ocnt_r <= wr_r;
      if (cmd.exec_cmd) begin
        unique case (cur_r.action)
          poet_pkg::ACT_START_REC: begin
            if (rcnt_r < RW'(REC_SLOTS)) begin
              rid_r[RIW'(rcnt_r)] <= cur_r.event_id;
              rph_r[RIW'(rcnt_r)] <= cur_r.phase;
              rcnt_r <= rcnt_r + 1'b1;
            end
          end
          poet_pkg::ACT_KILL_REC: begin
            if (rfound) begin
              for (int i = 0; i < REC_SLOTS - 1; i++)
                if (RIW'(i) >= rpos) begin
                  rid_r[i] <= rid_r[i+1];
                  rph_r[i] <= rph_r[i+1];
                end
              rcnt_r <= rcnt_r - 1'b1;
            end
          end
          poet_pkg::ACT_START_ONE: begin
            if (ocnt_r < OW'(ONE_SLOTS)) begin
              oid_r[OIW'(ocnt_r)] <= cur_r.event_id;
              oph_r[OIW'(ocnt_r)] <= cur_r.phase;
              otm_r[OIW'(ocnt_r)] <= cur_r.time_value;
              ocnt_r <= ocnt_r + 1'b1;
            end
          end
          poet_pkg::ACT_LENGTHEN: begin
            if (ofound) otm_r[opos] <= lsat;
          end
          poet_pkg::ACT_EXTING: begin
            if (ofound) begin
              for (int i = 0; i < ONE_SLOTS - 1; i++)
                if (OIW'(i) >= opos) begin
                  oid_r[i] <= oid_r[i+1];
                  oph_r[i] <= oph_r[i+1];
                  otm_r[i] <= otm_r[i+1];
                end
              ocnt_r <= ocnt_r - 1'b1;
            end
          end
          default: ;
        endcase
      end
    end
  end

  assign out_valid = oval_r;
  assign out_item  = oitem_r;

endmodule

FILE: hdl/periodic_and_oneshot_event_table.sv
// ----------------------------------------------------------------------------
// periodic_and_oneshot_event_table
// Recurring and one-shot event tables driven by start/busy commands.
// ----------------------------------------------------------------------------
// channel  | ports                        | handshake
// input    | in_item                      | start && !busy
// result   | out_item                     | out_valid, one cycle, no stall
//
// A command holds busy through the decode state only; its single result is
// on the ports in the cycle after that state, when busy is already low.
// A phase tick holds busy through decode, the recurring walk, the one-shot walk
// and the final state, one filled slot examined per cycle; each fired result
// streams out once the next is found, the final one in the first idle cycle.
// Reset clears both fill counts; the slots themselves are not cleared.
// The receiver cannot stall; results are never held.
// ----------------------------------------------------------------------------
module periodic_and_oneshot_event_table #(
  parameter int REC_SLOTS = poet_pkg::REC_SLOTS_DEF,
  parameter int ONE_SLOTS = poet_pkg::ONE_SLOTS_DEF,
  parameter int EVENT_IDS = poet_pkg::EVENT_IDS_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  poet_pkg::in_item_t  in_item,
  output logic                out_valid,
  output poet_pkg::out_item_t out_item
);

  poet_pkg::poet_cmd_t  cmd;
  poet_pkg::poet_stat_t stat;

  poet_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .stat(stat), .cmd(cmd)
  );

  poet_dp #(
    .REC_SLOTS(REC_SLOTS), .ONE_SLOTS(ONE_SLOTS), .EVENT_IDS(EVENT_IDS)
  ) u_dp (
    .clk(clk), .rst_n(rst_n), .in_item(in_item), .cmd(cmd), .stat(stat),
    .out_valid(out_valid), .out_item(out_item)
  );

  a_idle_no_out: assert property (@(posedge clk) disable iff (!rst_n)
    (!busy && !$past(busy)) |-> !out_valid) else $error("result while idle");

  a_last_ends: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_item.last) |-> !busy) else $error("busy with last result");

  a_cmd_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_item.fired_valid) |-> out_item.last)
    else $error("non-fired result without last");

endmodule
